// ===== rtl/core/gclv_pkg.sv =====
// Shared types, codes and helpers for the G-code line checksum validator.
// Depends on nothing; every module of the block imports it.
package gclv_pkg;

   // Longest line that still counts; later bytes up to the terminator are dropped
   localparam int MAX_LINE_DEFAULT = 64;

   // Character codes
   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_STAR  = 8'h2A;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;
   localparam logic [7:0] CH_N     = 8'h4E;
   localparam logic [7:0] CH_UC_T  = 8'h54;
   localparam logic [7:0] CH_LC_T  = 8'h74;
   localparam logic [7:0] CH_UC_G  = 8'h47;
   localparam logic [7:0] CH_LC_G  = 8'h67;
   localparam logic [7:0] CH_UC_M  = 8'h4D;
   localparam logic [7:0] CH_LC_M  = 8'h6D;

   // M code that reloads the line counter
   localparam logic [15:0] LINE_RESET_CODE = 16'd110;

   // Saturation limits of the decimal fields
   localparam logic [31:0] LIM_16 = 32'h0000_FFFF;
   localparam logic [31:0] LIM_31 = 32'h7FFF_FFFF;
   localparam logic [31:0] LIM_32 = 32'hFFFF_FFFF;

   // Command letter classes as held during a line (0 means none)
   localparam logic [1:0] LETTER_NONE = 2'd0;
   localparam logic [1:0] LETTER_T    = 2'd1;
   localparam logic [1:0] LETTER_G    = 2'd2;
   localparam logic [1:0] LETTER_M    = 2'd3;

   // Verdict codes
   localparam logic [1:0] VERDICT_ACCEPT  = 2'd0;
   localparam logic [1:0] VERDICT_BAD_SUM = 2'd1;
   localparam logic [1:0] VERDICT_ORDER   = 2'd2;
   localparam logic [1:0] VERDICT_NO_CMD  = 2'd3;

   // How the line began
   typedef enum logic [1:0] {
      MODE_START,
      MODE_NPEND,
      MODE_NUM,
      MODE_UNNUM
   } gclv_mode_type;

   // Command token parse phase
   typedef enum logic [2:0] {
      PH_SEEK,
      PH_LETTERS,
      PH_CODE,
      PH_TOKEN,
      PH_ARGSKIP,
      PH_ARG,
      PH_DONE,
      PH_NONE
   } gclv_phase_type;

   // Summary of the line seen so far, parser to verdict logic
   typedef struct packed {
      logic        numbered;
      logic        star_seen;
      logic        star_digits;
      logic [15:0] star_checksum;
      logic [7:0]  running_xor;
      logic [1:0]  letter_seen;
      logic [15:0] code_value;
      logic [30:0] number_value;
      logic [31:0] reset_argument;
      logic        arg_present;
   } gclv_line_type;

   // One result item
   typedef struct packed {
      logic [31:0] expected_line;
      logic [31:0] resend_line;
      logic [30:0] line_number;
      logic        had_line_number;
      logic [15:0] cmd_code;
      logic [1:0]  cmd_letter;
      logic [1:0]  verdict;
   } gclv_result_type;

   function automatic logic is_digit(input logic [7:0] c);
      return (c >= CH_ZERO) && (c <= CH_NINE);
   endfunction

   function automatic logic [1:0] letter_class(input logic [7:0] c);
      logic [1:0] l;
      l = LETTER_NONE;
      if (c == CH_UC_T || c == CH_LC_T) l = LETTER_T;
      else if (c == CH_UC_G || c == CH_LC_G) l = LETTER_G;
      else if (c == CH_UC_M || c == CH_LC_M) l = LETTER_M;
      return l;
   endfunction

   // Append one decimal digit, saturating at lim; v*10 as two shifts and an add
   function automatic logic [31:0] dec_acc(input logic [31:0] v, input logic [7:0] c,
                                           input logic [31:0] lim);
      logic [35:0] r;
      r = ({4'b0, v} << 3) + ({4'b0, v} << 1) + {32'b0, c[3:0]};
      return (r > {4'b0, lim}) ? lim : r[31:0];
   endfunction

endpackage

// ===== rtl/core/gclv_parser.sv =====
// Per-line parser: framing, running XOR, N number, star checksum and command token.
// Depends on gclv_pkg.
module gclv_parser #(
   parameter int MAX_LINE = gclv_pkg::MAX_LINE_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   step,
   input  logic [7:0]             rx_byte,
   output logic                   line_empty,
   output gclv_pkg::gclv_line_type line
);
   import gclv_pkg::*;

   localparam int CW = $clog2(MAX_LINE + 1);
   localparam logic [CW-1:0] LIMIT = CW'(MAX_LINE);

   logic [7:0]     running_xor_ff, running_xor_in;
   logic [CW-1:0]  byte_count_ff, byte_count_in;
   gclv_phase_type phase_ff, phase_in;
   logic [30:0]    number_value_ff, number_value_in;
   logic [15:0]    star_checksum_ff, star_checksum_in;
   logic           star_seen_ff, star_seen_in;
   logic [1:0]     letter_seen_ff, letter_seen_in;
   logic [15:0]    code_value_ff, code_value_in;
   logic [31:0]    reset_argument_ff, reset_argument_in;
   logic           arg_present_ff, arg_present_in;
   gclv_mode_type  mode_ff, mode_in;
   logic           num_active_ff, num_active_in;
   logic           star_active_ff, star_active_in;
   logic           star_digits_ff, star_digits_in;

   logic           digit, is_term;
   logic [1:0]     letter;
   logic [31:0]    code_acc, number_acc, star_acc, arg_acc;

   // Command token feed results
   gclv_phase_type feed_phase;
   logic [1:0]     feed_letter;
   logic [15:0]    feed_code;
   logic [31:0]    feed_arg;
   logic           feed_arg_present;
   logic           feed_numbered;

   assign digit      = is_digit(rx_byte);
   assign letter     = letter_class(rx_byte);
   assign is_term    = (rx_byte == CH_LF) || (rx_byte == CH_CR);
   assign code_acc   = dec_acc({16'b0, code_value_ff}, rx_byte, LIM_16);
   assign number_acc = dec_acc({1'b0, number_value_ff}, rx_byte, LIM_31);
   assign star_acc   = dec_acc({16'b0, star_checksum_ff}, rx_byte, LIM_16);
   assign arg_acc    = dec_acc(reset_argument_ff, rx_byte, LIM_32);

   // Advance the command token parser by one byte
   always_comb begin
      feed_phase       = phase_ff;
      feed_letter      = letter_seen_ff;
      feed_code        = code_value_ff;
      feed_arg         = reset_argument_ff;
      feed_arg_present = arg_present_ff;
      feed_numbered    = (mode_ff == MODE_NUM);
      unique case (phase_ff)
         PH_SEEK: begin
            if (letter != LETTER_NONE) begin
               feed_letter = letter;
               feed_phase  = PH_LETTERS;
            end else if (!feed_numbered && rx_byte != CH_SPACE) begin
               feed_phase = PH_NONE;
            end
         end
         PH_LETTERS, PH_CODE: begin
            if (digit) begin
               feed_code  = code_acc[15:0];
               feed_phase = PH_CODE;
            end else if (rx_byte == CH_SPACE) begin
               feed_phase = PH_ARGSKIP;
            end else if (!(phase_ff == PH_LETTERS && letter != LETTER_NONE)) begin
               feed_phase = PH_TOKEN;
            end
         end
         PH_TOKEN: begin
            if (rx_byte == CH_SPACE) feed_phase = PH_ARGSKIP;
         end
         PH_ARGSKIP, PH_ARG: begin
            if (digit) begin
               feed_arg         = arg_acc;
               feed_arg_present = 1'b1;
               feed_phase       = PH_ARG;
            end else if (!(phase_ff == PH_ARGSKIP && rx_byte == CH_SPACE)) begin
               feed_phase = PH_DONE;
            end
         end
         default: begin
         end
      endcase
   end

   // Next line state: clear on a terminator, drop bytes past the limit
   always_comb begin
      running_xor_in    = running_xor_ff;
      byte_count_in     = byte_count_ff;
      phase_in          = phase_ff;
      number_value_in   = number_value_ff;
      star_checksum_in  = star_checksum_ff;
      star_seen_in      = star_seen_ff;
      letter_seen_in    = letter_seen_ff;
      code_value_in     = code_value_ff;
      reset_argument_in = reset_argument_ff;
      arg_present_in    = arg_present_ff;
      mode_in           = mode_ff;
      num_active_in     = num_active_ff;
      star_active_in    = star_active_ff;
      star_digits_in    = star_digits_ff;
      if (step && is_term) begin
         running_xor_in    = '0;
         byte_count_in     = '0;
         phase_in          = PH_SEEK;
         number_value_in   = '0;
         star_checksum_in  = '0;
         star_seen_in      = 1'b0;
         letter_seen_in    = LETTER_NONE;
         code_value_in     = '0;
         reset_argument_in = '0;
         arg_present_in    = 1'b0;
         mode_in           = MODE_START;
         num_active_in     = 1'b0;
         star_active_in    = 1'b0;
         star_digits_in    = 1'b0;
      end else if (step && byte_count_ff < LIMIT) begin
         byte_count_in = byte_count_ff + 1'b1;

         // Checksum side: XOR up to the star, then its decimal value
         if (!star_seen_ff) begin
            if (rx_byte == CH_STAR) begin
               star_seen_in   = 1'b1;
               star_active_in = 1'b1;
            end else begin
               running_xor_in = running_xor_ff ^ rx_byte;
            end
         end else if (star_active_ff) begin
            if (digit) begin
               star_checksum_in = star_acc[15:0];
               star_digits_in   = 1'b1;
            end else begin
               star_active_in = 1'b0;
            end
         end

         // Line number and command side
         unique case (mode_ff)
            MODE_START: begin
               if (rx_byte == CH_N) begin
                  mode_in = MODE_NPEND;
               end else begin
                  mode_in           = MODE_UNNUM;
                  phase_in          = feed_phase;
                  letter_seen_in    = feed_letter;
                  code_value_in     = feed_code;
                  reset_argument_in = feed_arg;
                  arg_present_in    = feed_arg_present;
               end
            end
            MODE_NPEND: begin
               if (digit) begin
                  mode_in         = MODE_NUM;
                  num_active_in   = 1'b1;
                  number_value_in = {27'b0, rx_byte[3:0]};
               end else begin
                  mode_in  = MODE_UNNUM;
                  phase_in = PH_NONE;
               end
            end
            MODE_NUM: begin
               if (num_active_ff) begin
                  if (digit) number_value_in = number_acc[30:0];
                  else num_active_in = 1'b0;
               end
               if (!star_seen_ff && rx_byte != CH_STAR) begin
                  phase_in          = feed_phase;
                  letter_seen_in    = feed_letter;
                  code_value_in     = feed_code;
                  reset_argument_in = feed_arg;
                  arg_present_in    = feed_arg_present;
               end
            end
            default: begin
               phase_in          = feed_phase;
               letter_seen_in    = feed_letter;
               code_value_in     = feed_code;
               reset_argument_in = feed_arg;
               arg_present_in    = feed_arg_present;
            end
         endcase
      end
   end

   // Hold the line state
   always_ff @(posedge clock) begin
      if (reset) begin
         running_xor_ff    <= '0;
         byte_count_ff     <= '0;
         phase_ff          <= PH_SEEK;
         number_value_ff   <= '0;
         star_checksum_ff  <= '0;
         star_seen_ff      <= 1'b0;
         letter_seen_ff    <= LETTER_NONE;
         code_value_ff     <= '0;
         reset_argument_ff <= '0;
         arg_present_ff    <= 1'b0;
         mode_ff           <= MODE_START;
         num_active_ff     <= 1'b0;
         star_active_ff    <= 1'b0;
         star_digits_ff    <= 1'b0;
      end else begin
         running_xor_ff    <= running_xor_in;
         byte_count_ff     <= byte_count_in;
         phase_ff          <= phase_in;
         number_value_ff   <= number_value_in;
         star_checksum_ff  <= star_checksum_in;
         star_seen_ff      <= star_seen_in;
         letter_seen_ff    <= letter_seen_in;
         code_value_ff     <= code_value_in;
         reset_argument_ff <= reset_argument_in;
         arg_present_ff    <= arg_present_in;
         mode_ff           <= mode_in;
         num_active_ff     <= num_active_in;
         star_active_ff    <= star_active_in;
         star_digits_ff    <= star_digits_in;
      end
   end

   // Export the summary for the end-of-line decision
   assign line_empty          = (byte_count_ff == '0);
   assign line.numbered       = (mode_ff == MODE_NUM);
   assign line.star_seen      = star_seen_ff;
   assign line.star_digits    = star_digits_ff;
   assign line.star_checksum  = star_checksum_ff;
   assign line.running_xor    = running_xor_ff;
   assign line.letter_seen    = letter_seen_ff;
   assign line.code_value     = code_value_ff;
   assign line.number_value   = number_value_ff;
   assign line.reset_argument = reset_argument_ff;
   assign line.arg_present    = arg_present_ff;

endmodule

// ===== rtl/core/gclv_verdict.sv =====
// End-of-line decision: checksum and order checks, line counter, result item.
// Depends on gclv_pkg.
module gclv_verdict (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     fire,
   input  gclv_pkg::gclv_line_type   line,
   output gclv_pkg::gclv_result_type result
);
   import gclv_pkg::*;

   logic [31:0] last_line_ff, last_line_in;
   logic [31:0] next_line;
   logic        is_reset, sum_bad, out_of_order;

   assign next_line    = last_line_ff + 32'd1;
   assign is_reset     = (line.letter_seen == LETTER_M) && (line.code_value == LINE_RESET_CODE);
   assign sum_bad      = line.numbered && (!line.star_seen || !line.star_digits ||
                         line.star_checksum != {8'b0, line.running_xor});
   assign out_of_order = line.numbered && ({1'b0, line.number_value} != next_line) && !is_reset;

   // Decide the verdict and the new line counter
   always_comb begin
      last_line_in           = last_line_ff;
      result.verdict         = VERDICT_ACCEPT;
      result.cmd_letter      = 2'd0;
      result.cmd_code        = '0;
      result.resend_line     = '0;
      if (sum_bad) begin
         result.verdict     = VERDICT_BAD_SUM;
         result.resend_line = next_line;
      end else if (line.letter_seen == LETTER_NONE) begin
         result.verdict = VERDICT_NO_CMD;
      end else begin
         result.cmd_letter = line.letter_seen - 2'd1;
         result.cmd_code   = line.code_value;
         if (out_of_order) begin
            result.verdict     = VERDICT_ORDER;
            result.resend_line = next_line;
         end else if (is_reset) begin
            last_line_in = line.arg_present ? line.reset_argument : 32'd1;
         end else if (line.numbered) begin
            last_line_in = next_line;
         end
      end
      result.had_line_number = line.numbered;
      result.line_number     = line.numbered ? line.number_value : '0;
      result.expected_line   = last_line_in;
   end

   // Advance the line counter only when a line closes
   always_ff @(posedge clock) begin
      if (reset) begin
         last_line_ff <= '0;
      end else if (fire) begin
         last_line_ff <= last_line_in;
      end
   end

endmodule

// ===== rtl/core/gcode_line_checksum_validator.sv =====
// Top level of the G-code line checksum validator: input register, parser,
// verdict logic and result register. Depends on gclv_pkg, gclv_parser, gclv_verdict.
//
//  channel  direction  transfer on             contents
//  req_     in         req_tvalid & req_tready one received byte
//  rsp_     out        rsp_tvalid & rsp_tready one verdict per non-empty line
//
// One byte per cycle sustained while no waiting result holds back a closing line;
// a terminator's byte is held in the input register and its verdict is captured
// in the result register when that byte steps on.
// Reset is synchronous and clears the line state, the line counter and both valids.
// A waiting result stalls the parser only when another line closes behind it;
// the input register accepts a new byte whenever the parser moves on.
module gcode_line_checksum_validator #(
   parameter int MAX_LINE = gclv_pkg::MAX_LINE_DEFAULT
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   input  logic [7:0]    req_tdata,   // [7:0] rx_byte
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   output logic [119:0]  rsp_tdata    // [1:0] verdict, [3:2] cmd_letter, [19:4] cmd_code,
                                      // [20] had_line_number, [51:21] line_number,
                                      // [83:52] resend_line, [115:84] expected_line, zero pad
);
   import gclv_pkg::*;

   logic            in_valid_ff, in_valid_in;
   logic [7:0]      in_byte_ff;
   logic            out_valid_ff, out_valid_in;
   gclv_result_type out_result_ff;

   logic            step, is_term, closes, fire, line_empty;
   gclv_line_type   line;
   gclv_result_type result;

   // A byte moves on unless it closes a line while the result register is full and not being taken
   assign is_term    = (in_byte_ff == CH_LF) || (in_byte_ff == CH_CR);
   assign closes     = is_term && !line_empty;
   assign step       = in_valid_ff && (!closes || !out_valid_ff || rsp_tready);
   assign fire       = step && closes;
   assign req_tready = !in_valid_ff || step;

   gclv_parser #(
      .MAX_LINE(MAX_LINE)
   ) u_parser (
      .clock      (clock),
      .reset      (reset),
      .step       (step),
      .rx_byte    (in_byte_ff),
      .line_empty (line_empty),
      .line       (line)
   );

   gclv_verdict u_verdict (
      .clock  (clock),
      .reset  (reset),
      .fire   (fire),
      .line   (line),
      .result (result)
   );

   // Input register: load on transfer, drop once stepped
   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_tvalid && req_tready) in_valid_in = 1'b1;
      else if (step) in_valid_in = 1'b0;
   end

   // Result register: load on a closed line, drop once taken
   always_comb begin
      out_valid_in = out_valid_ff;
      if (fire) out_valid_in = 1'b1;
      else if (rsp_tready) out_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Hold payloads
   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) in_byte_ff <= req_tdata;
      if (fire) out_result_ff <= result;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {4'b0, out_result_ff};

   // A new result only follows a byte that was waiting in the input register
   a_result_from_byte : assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(in_valid_ff))
      else $error("result appeared without a pending byte");

   // Accepted or commandless lines never ask for a resend
   a_no_resend : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (out_result_ff.verdict == VERDICT_ACCEPT ||
                     out_result_ff.verdict == VERDICT_NO_CMD)
      |-> out_result_ff.resend_line == 32'd0)
      else $error("resend line set without a resend verdict");

   // Unnumbered lines carry no number and cannot fail the checksum
   a_unnumbered : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !out_result_ff.had_line_number
      |-> out_result_ff.line_number == 31'd0 && out_result_ff.verdict != VERDICT_BAD_SUM)
      else $error("unnumbered line reported a number or a bad checksum");

   // A bad checksum discards the command
   a_bad_sum_clear : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && out_result_ff.verdict == VERDICT_BAD_SUM
      |-> out_result_ff.cmd_letter == 2'd0 && out_result_ff.cmd_code == 16'd0)
      else $error("command reported on a bad checksum line");

endmodule

// ===== sim/tb.sv =====
// Testbench for gcode_line_checksum_validator: streams received bytes into the block
// and checks every line verdict against a behavioral predictor kept in this file.
// Depends on gclv_pkg and the RTL top level only.
`timescale 1ns / 100ps

module tb;
   import gclv_pkg::*;

   localparam int LINE_LIMIT   = 64;
   localparam int CYCLE_LIMIT  = 1000000;
   localparam int RANDOM_BYTES = 900;
   localparam int SETTLE       = 8;

   // How a numbered line is closed
   typedef enum int {
      SUM_GOOD,
      SUM_WRONG,
      SUM_NONE,
      SUM_EMPTY
   } sum_kind_type;

   logic          clock;
   logic          reset      = 1'b1;
   logic          req_tvalid = 1'b0;
   logic          req_tready;
   logic [7:0]    req_tdata  = 8'h00;   // [7:0] rx_byte
   logic          rsp_tvalid;
   logic          rsp_tready = 1'b0;
   logic [119:0]  rsp_tdata;            // [1:0] verdict, [3:2] cmd_letter, [19:4] cmd_code,
                                        // [20] had_line_number, [51:21] line_number,
                                        // [83:52] resend_line, [115:84] expected_line

   gcode_line_checksum_validator #(
      .MAX_LINE (LINE_LIMIT)
   ) u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   // Expected verdicts, oldest first, and run bookkeeping
   gclv_result_type pending_verdicts[$];
   logic [7:0]      line_buf[$];
   int              errors        = 0;
   int              bytes_sent    = 0;
   int              lines_checked = 0;
   int              verdict_count[4];
   int              cycle_count   = 0;
   int              stall_cycles  = 0;
   bit              req_burst     = 1'b0;
   bit              rsp_burst     = 1'b0;

   // Line checker state as the predictor holds it
   logic [31:0]     ln_last;
   logic [7:0]      ln_xor;
   int              ln_count;
   gclv_phase_type  ln_phase;
   logic [31:0]     ln_number;
   logic [15:0]     ln_star;
   bit              ln_star_seen;
   bit              ln_star_active;
   bit              ln_star_digits;
   logic [1:0]      ln_letter;
   logic [15:0]     ln_code;
   logic [31:0]     ln_arg;
   bit              ln_arg_present;
   gclv_mode_type   ln_mode;
   bit              ln_num_active;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // ---------------------------------------------------------------- predictor

   function automatic bit digit_char(input logic [7:0] c);
      return (c >= CH_ZERO) && (c <= CH_NINE);
   endfunction

   function automatic logic [1:0] command_class(input logic [7:0] c);
      case (c)
         CH_UC_T, CH_LC_T: return LETTER_T;
         CH_UC_G, CH_LC_G: return LETTER_G;
         CH_UC_M, CH_LC_M: return LETTER_M;
         default:          return LETTER_NONE;
      endcase
   endfunction

   // Shift one decimal digit in, clamping at lim
   function automatic logic [31:0] append_decimal(input logic [31:0] v, input logic [7:0] c,
                                                  input logic [31:0] lim);
      logic [63:0] r;
      r = {32'b0, v} * 64'd10 + {60'b0, c[3:0]};
      return (r > {32'b0, lim}) ? lim : r[31:0];
   endfunction

   function automatic void clear_line_state();
      ln_xor         = '0;
      ln_count       = 0;
      ln_phase       = PH_SEEK;
      ln_number      = '0;
      ln_star        = '0;
      ln_star_seen   = 1'b0;
      ln_star_active = 1'b0;
      ln_star_digits = 1'b0;
      ln_letter      = LETTER_NONE;
      ln_code        = '0;
      ln_arg         = '0;
      ln_arg_present = 1'b0;
      ln_mode        = MODE_START;
      ln_num_active  = 1'b0;
   endfunction

   // Track the command token, its code and the M110 argument
   function automatic void track_command(input logic [7:0] c, input bit numbered);
      logic [1:0]  cls;
      logic [31:0] acc;
      cls = command_class(c);
      case (ln_phase)
         PH_SEEK: begin
            if (cls != LETTER_NONE) begin
               ln_letter = cls;
               ln_phase  = PH_LETTERS;
            end else if (!numbered && c != CH_SPACE) begin
               ln_phase = PH_NONE;
            end
         end
         PH_LETTERS, PH_CODE: begin
            if (digit_char(c)) begin
               acc      = append_decimal({16'b0, ln_code}, c, LIM_16);
               ln_code  = acc[15:0];
               ln_phase = PH_CODE;
            end else if (c == CH_SPACE) begin
               ln_phase = PH_ARGSKIP;
            end else if (!(ln_phase == PH_LETTERS && cls != LETTER_NONE)) begin
               ln_phase = PH_TOKEN;
            end
         end
         PH_TOKEN: begin
            if (c == CH_SPACE) ln_phase = PH_ARGSKIP;
         end
         PH_ARGSKIP, PH_ARG: begin
            if (digit_char(c)) begin
               ln_arg         = append_decimal(ln_arg, c, LIM_32);
               ln_arg_present = 1'b1;
               ln_phase       = PH_ARG;
            end else if (!(ln_phase == PH_ARGSKIP && c == CH_SPACE)) begin
               ln_phase = PH_DONE;
            end
         end
         default: ;
      endcase
   endfunction

   // Advance the line checker by one accepted byte; queue a verdict at the end of a non-empty line
   function automatic void predict_byte(input logic [7:0] c);
      bit              numbered;
      bit              is_reset;
      bit              before_star;
      logic [31:0]     acc;
      gclv_result_type res;

      if (c == CH_LF || c == CH_CR) begin
         if (ln_count == 0) begin
            clear_line_state();
            return;
         end
         numbered = (ln_mode == MODE_NUM);
         is_reset = (ln_letter == LETTER_M) && (ln_code == LINE_RESET_CODE);
         res = '0;
         if (numbered && (!ln_star_seen || !ln_star_digits || ln_star != {8'h00, ln_xor})) begin
            res.verdict     = VERDICT_BAD_SUM;
            res.resend_line = ln_last + 32'd1;
         end else if (ln_letter == LETTER_NONE) begin
            res.verdict = VERDICT_NO_CMD;
         end else begin
            res.cmd_letter = ln_letter - 2'd1;
            res.cmd_code   = ln_code;
            if (numbered && ln_number != ln_last + 32'd1 && !is_reset) begin
               res.verdict     = VERDICT_ORDER;
               res.resend_line = ln_last + 32'd1;
            end else begin
               res.verdict = VERDICT_ACCEPT;
               if (numbered) ln_last = ln_last + 32'd1;
               if (is_reset) ln_last = ln_arg_present ? ln_arg : 32'd1;
            end
         end
         res.had_line_number = numbered;
         res.line_number     = numbered ? ln_number[30:0] : '0;
         res.expected_line   = ln_last;
         pending_verdicts.push_back(res);
         clear_line_state();
         return;
      end

      // Drop bytes past the line limit
      if (ln_count >= LINE_LIMIT) return;
      ln_count++;

      // Running XOR up to the star, then the checksum digits
      before_star = !ln_star_seen;
      if (!ln_star_seen) begin
         if (c == CH_STAR) begin
            ln_star_seen   = 1'b1;
            ln_star_active = 1'b1;
         end else begin
            ln_xor = ln_xor ^ c;
         end
      end else if (ln_star_active) begin
         if (digit_char(c)) begin
            acc            = append_decimal({16'b0, ln_star}, c, LIM_16);
            ln_star        = acc[15:0];
            ln_star_digits = 1'b1;
         end else begin
            ln_star_active = 1'b0;
         end
      end

      case (ln_mode)
         MODE_START: begin
            if (c == CH_N) begin
               ln_mode = MODE_NPEND;
            end else begin
               ln_mode = MODE_UNNUM;
               track_command(c, 1'b0);
            end
         end
         MODE_NPEND: begin
            if (digit_char(c)) begin
               ln_mode       = MODE_NUM;
               ln_num_active = 1'b1;
               ln_number     = {28'b0, c[3:0]};
            end else begin
               ln_mode  = MODE_UNNUM;
               ln_phase = PH_NONE;
            end
         end
         MODE_NUM: begin
            if (ln_num_active) begin
               if (digit_char(c)) ln_number = append_decimal(ln_number, c, LIM_31);
               else ln_num_active = 1'b0;
            end
            if (before_star && c != CH_STAR) track_command(c, 1'b1);
         end
         default: track_command(c, 1'b0);
      endcase
   endfunction

   initial begin
      ln_last = '0;
      clear_line_state();
   end

   // ---------------------------------------------------------------- checking

   task automatic check_field(input string field, input logic [31:0] want,
                              input logic [31:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %h actual %h", $time, field, want, got);
         errors++;
      end
   endtask

   task automatic check_result(input logic [119:0] raw);
      gclv_result_type got;
      gclv_result_type want;
      got = raw[115:0];
      if (pending_verdicts.size() == 0) begin
         $display("%0t: result with nothing expected, expected none actual %h", $time, raw);
         errors++;
         return;
      end
      want = pending_verdicts.pop_front();
      check_field("verdict", want.verdict, got.verdict);
      check_field("cmd_letter", want.cmd_letter, got.cmd_letter);
      check_field("cmd_code", want.cmd_code, got.cmd_code);
      check_field("had_line_number", want.had_line_number, got.had_line_number);
      check_field("line_number", want.line_number, got.line_number);
      check_field("resend_line", want.resend_line, got.resend_line);
      check_field("expected_line", want.expected_line, got.expected_line);
      check_field("pad", 32'd0, raw[119:116]);
      verdict_count[want.verdict]++;
      lines_checked++;
   endtask

   // Check each result transfer
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) check_result(rsp_tdata);
   end

   // Result side: random hold-off per transfer outside bursts, plus a long stall on request
   initial begin
      int gap;
      do @(posedge clock); while (reset);
      forever begin
         if (stall_cycles > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall_cycles) @(posedge clock);
            stall_cycles = 0;
         end
         gap = rsp_burst ? 0 : $urandom_range(0, 19);
         if (gap > 0) begin
            rsp_tready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!(rsp_tvalid && rsp_tready) && stall_cycles == 0);
      end
   end

   // Abort a hung run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("%0t: timeout after %0d cycles, %0d verdicts outstanding",
                  $time, cycle_count, pending_verdicts.size());
         $display("FAILURE");
         $finish;
      end
   end

   // ---------------------------------------------------------------- stimulus

   // Offer one byte after a random gap, none in a burst, and hold it until the transfer
   task automatic send_byte(input logic [7:0] b);
      int gap;
      gap = req_burst ? 0 : $urandom_range(0, 19);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      do @(posedge clock); while (!req_tready);
      predict_byte(b);
      bytes_sent++;
   endtask

   // Stop sending until every verdict has come back
   task automatic wait_for_results();
      req_tvalid <= 1'b0;
      while (pending_verdicts.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   function automatic void put_str(input string s);
      for (int i = 0; i < s.len(); i++) line_buf.push_back(s[i]);
   endfunction

   function automatic void put_dec(input logic [63:0] v);
      put_str($sformatf("%0d", v));
   endfunction

   // Append star and checksum of the buffer: good, wrong, star only, or nothing
   function automatic void close_numbered(input sum_kind_type kind);
      logic [7:0] x;
      x = '0;
      foreach (line_buf[i]) x = x ^ line_buf[i];
      case (kind)
         SUM_GOOD: begin
            line_buf.push_back(CH_STAR);
            put_dec(x);
         end
         SUM_WRONG: begin
            line_buf.push_back(CH_STAR);
            put_dec(x ^ 8'($urandom_range(1, 255)));
         end
         SUM_EMPTY: line_buf.push_back(CH_STAR);
         default: ;
      endcase
   endfunction

   function automatic void put_terminator();
      case ($urandom_range(0, 2))
         0: line_buf.push_back(CH_LF);
         1: line_buf.push_back(CH_CR);
         default: begin
            line_buf.push_back(CH_CR);
            line_buf.push_back(CH_LF);
         end
      endcase
   endfunction

   task automatic send_line();
      foreach (line_buf[i]) send_byte(line_buf[i]);
      line_buf.delete();
   endtask

   task automatic send_text(input string s);
      put_str(s);
      send_line();
   endtask

   task automatic send_numbered(input logic [63:0] num, input string body,
                                input sum_kind_type kind);
      put_str("N");
      put_dec(num);
      put_str(body);
      close_numbered(kind);
      line_buf.push_back(CH_LF);
      send_line();
   endtask

   // Random command token with optional parameters
   function automatic void put_command();
      string letters = "TtGgMm";
      string params  = "XYZEFS";
      int    n;
      if ($urandom_range(0, 9) == 0) begin
         put_str($urandom_range(0, 1) ? "M110" : "m110");
         case ($urandom_range(0, 3))
            0: ;
            1: begin
               put_str(" ");
               put_dec($urandom_range(0, 2000));
            end
            2: put_str(" N12");
            default: begin
               put_str("  ");
               put_dec($urandom_range(0, 50));
            end
         endcase
         return;
      end
      line_buf.push_back(letters[$urandom_range(0, 5)]);
      if ($urandom_range(0, 9) == 0) line_buf.push_back(letters[$urandom_range(0, 5)]);
      case ($urandom_range(0, 7))
         0: ;
         1: put_dec($urandom_range(0, 999999));
         default: put_dec($urandom_range(0, 400));
      endcase
      n = $urandom_range(0, 3);
      repeat (n) begin
         put_str(" ");
         line_buf.push_back(params[$urandom_range(0, 5)]);
         if ($urandom_range(0, 4) == 0) put_str("-");
         put_dec($urandom_range(0, 5000));
         if ($urandom_range(0, 2) == 0) put_str(".5");
      end
   endfunction

   // One random line: mostly well-formed numbered traffic, then the odd cases
   task automatic send_random_line();
      int pick;
      int len;
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
         put_str("N");
         put_dec({32'b0, ln_last} + 64'd1);
         if ($urandom_range(0, 3) != 0) put_str(" ");
         put_command();
         close_numbered(($urandom_range(0, 9) == 0) ? sum_kind_type'($urandom_range(1, 3))
                                                    : SUM_GOOD);
      end else if (pick < 65) begin
         put_str("N");
         put_dec($urandom_range(0, 1) ? {32'b0, ln_last} + 64'd2 + $urandom_range(0, 5)
                                      : 64'($urandom_range(0, 100000)));
         put_str(" ");
         put_command();
         close_numbered(SUM_GOOD);
      end else if (pick < 80) begin
         if ($urandom_range(0, 3) == 0) put_str(" ");
         put_command();
      end else if (pick < 93) begin
         len = $urandom_range(1, 12);
         repeat (len) line_buf.push_back(8'($urandom_range(0, 255)));
      end else begin
         if ($urandom_range(0, 1)) begin
            put_str("N");
            put_dec({32'b0, ln_last} + 64'd1);
         end
         put_str(" G1");
         len = $urandom_range(50, 90);
         repeat (len) line_buf.push_back(8'($urandom_range(32, 126)));
         close_numbered(SUM_GOOD);
      end
      put_terminator();
      send_line();
   endtask

   // ---------------------------------------------------------------- tests

   // Empty lines and lines without a line number
   task automatic test_unnumbered_lines();
      send_text("\n");
      send_text("\r\n");
      send_text("G28\n");
      send_text("t1\r");
      send_text("m105\n");
      send_text("  G1 X5\n");
      send_text("X10 G1\n");
      send_text("GGM12\n");
      send_text("G-5\n");
      send_text("G999999\n");
      send_text("G1*5\n");
      send_text("N\n");
      send_text("NG1\n");
      send_text("M110\n");
   endtask

   // Line numbers, checksums and ordering
   task automatic test_numbered_lines();
      send_numbered(ln_last + 64'd1, " G1 X5", SUM_GOOD);
      send_numbered(ln_last + 64'd1, " G1 X5", SUM_WRONG);
      send_numbered(ln_last + 64'd1, " G1 X5", SUM_NONE);
      send_numbered(ln_last + 64'd1, " G1 X5", SUM_EMPTY);
      send_text($sformatf("N%0d G1*123456\n", ln_last + 32'd1));
      send_numbered(ln_last + 64'd3, " G1", SUM_GOOD);
      send_numbered(ln_last + 64'd1, " X5 Y6", SUM_GOOD);
      send_numbered(ln_last + 64'd1, " X5 M3", SUM_GOOD);
      send_numbered(64'd99999999999, " G1", SUM_GOOD);
      // bytes at both ends of the range inside the checksum
      put_str("N");
      put_dec({32'b0, ln_last} + 64'd1);
      put_str(" G4 ");
      line_buf.push_back(8'hFF);
      line_buf.push_back(8'h80);
      line_buf.push_back(8'h00);
      line_buf.push_back(8'h7F);
      close_numbered(SUM_GOOD);
      line_buf.push_back(CH_CR);
      send_line();
   endtask

   // M110 reloads of the line counter, including wrap of the next line
   task automatic test_line_reset();
      send_numbered(64'd500, " M110 N100", SUM_GOOD);
      send_numbered(64'd7, " M110 42", SUM_GOOD);
      send_numbered(64'd43, " G1", SUM_GOOD);
      send_numbered(64'd44, " m110", SUM_GOOD);
      send_text("M110   77\n");
      send_text("M110 -5\n");
      send_numbered(64'd2, " M110 99999999999", SUM_GOOD);
      send_numbered(64'd0, " G1", SUM_GOOD);
   endtask

   // Lines longer than the limit; the star falls past it once
   task automatic test_long_lines();
      put_str("G1 ");
      repeat (80) put_str("X");
      put_str("\n");
      send_line();
      put_str("N");
      put_dec({32'b0, ln_last} + 64'd1);
      put_str(" G1 ");
      repeat (70) put_str("A");
      close_numbered(SUM_GOOD);
      put_str("\n");
      send_line();
      put_str("N");
      put_dec({32'b0, ln_last} + 64'd1);
      put_str(" G1 ");
      repeat (54) put_str("B");
      close_numbered(SUM_GOOD);
      put_str("\n");
      send_line();
   endtask

   // Stall the result side for a long stretch while bytes keep coming
   task automatic test_backpressure();
      stall_cycles = 300;
      req_burst    = 1'b1;
      for (int i = 0; i < 30; i++) begin
         if (i % 2 == 0) send_numbered(ln_last + 64'd1, " G1 X1", SUM_GOOD);
         else send_text("M105\n");
      end
      req_burst = 1'b0;
      wait_for_results();
   endtask

   // Random traffic with bursts on both sides now and then
   task automatic test_random_traffic();
      int target;
      target = bytes_sent + RANDOM_BYTES;
      while (bytes_sent < target) begin
         if ($urandom_range(0, 19) == 0) req_burst = ~req_burst;
         if ($urandom_range(0, 19) == 0) rsp_burst = ~rsp_burst;
         if ($urandom_range(0, 59) == 0) wait_for_results();
         send_random_line();
      end
      req_burst = 1'b0;
      rsp_burst = 1'b0;
   endtask

   // ---------------------------------------------------------------- sequence

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      test_unnumbered_lines();
      wait_for_results();
      test_numbered_lines();
      wait_for_results();
      test_line_reset();
      wait_for_results();
      test_long_lines();
      wait_for_results();
      test_backpressure();
      test_random_traffic();
      wait_for_results();
      $display("Streamed %0d bytes, checked %0d line verdicts in %0d cycles",
               bytes_sent, lines_checked, cycle_count);
      $display("Accepted %0d, bad checksum %0d, out of order %0d, no command %0d",
               verdict_count[VERDICT_ACCEPT], verdict_count[VERDICT_BAD_SUM],
               verdict_count[VERDICT_ORDER], verdict_count[VERDICT_NO_CMD]);
      if (errors == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
